// ===== sv/mcr_pkg.sv =====
// Shared constants, types and codes of the midpoint circle rasterizer.
`timescale 1ns / 1ps

package mcr_pkg;

    localparam int COORD_BITS = 12;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int PIX_BITS   = COORD_BITS + 2;
    localparam int DEC_BITS   = COORD_BITS + 2;
    localparam int OCT_BITS   = 3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [OCT_BITS-1:0] OCT_LAST = 3'd7;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [RAD_BITS-1:0]        rad_t;
    typedef logic signed [PIX_BITS-1:0] pix_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;
    typedef logic [OCT_BITS-1:0]        oct_t;

    // One iteration's worth of outline points, handed to the emitter
    typedef struct packed {
        coord_t cx;
        coord_t cy;
        rad_t   a;
        rad_t   b;
        logic   done;
    } job_t;

endpackage

// ===== sv/mcr_ifs.sv =====
// Valid/ready channel interfaces for commands and pixel results.
`timescale 1ns / 1ps

interface mcr_cmd_if;
    logic               valid;
    logic               ready;
    logic               action;
    mcr_pkg::coord_t    center_x;
    mcr_pkg::coord_t    center_y;
    mcr_pkg::rad_t      circle_radius;

    modport source (output valid, action, center_x, center_y, circle_radius, input ready);
    modport sink   (input valid, action, center_x, center_y, circle_radius, output ready);
endinterface

interface mcr_pix_if;
    logic               valid;
    logic               ready;
    mcr_pkg::pix_t      pixel_x;
    mcr_pkg::pix_t      pixel_y;
    mcr_pkg::oct_t      octant;
    logic               last_of_step;
    logic               circle_done;

    modport source (output valid, pixel_x, pixel_y, octant, last_of_step, circle_done,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, octant, last_of_step, circle_done,
                    output ready);
endinterface

// ===== sv/mcr_iter.sv =====
// Circle state; a start command loads the first point and each step accepted while busy runs one midpoint iteration.
`timescale 1ns / 1ps

module mcr_iter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            action,
    input  mcr_pkg::coord_t center_x,
    input  mcr_pkg::coord_t center_y,
    input  mcr_pkg::rad_t   circle_radius,
    output logic            job_load,
    output mcr_pkg::job_t   job
);

    localparam int W = mcr_pkg::DEC_BITS + 1;
    localparam logic signed [W-1:0] ONE   = W'(1);
    localparam logic signed [W-1:0] INC_E = W'(3);
    localparam logic signed [W-1:0] INC_SE = W'(5);

    mcr_pkg::rad_t   offset_a_reg, offset_a_next;
    mcr_pkg::rad_t   offset_b_reg, offset_b_next;
    mcr_pkg::dec_t   decision_reg, decision_next;
    mcr_pkg::coord_t held_cx_reg, held_cx_next;
    mcr_pkg::coord_t held_cy_reg, held_cy_next;
    logic            busy_reg, busy_next;

    logic signed [W-1:0] a_s, b_s, d_s, r_s, sum;

    always_comb
    begin
        a_s = $signed({{(W-mcr_pkg::RAD_BITS){1'b0}}, offset_a_reg});
        b_s = $signed({{(W-mcr_pkg::RAD_BITS){1'b0}}, offset_b_reg});
        r_s = $signed({{(W-mcr_pkg::RAD_BITS){1'b0}}, circle_radius});
        d_s = W'(decision_reg);
        if (decision_reg < 0)
            sum = d_s + (a_s <<< 1) + INC_E;
        else
            sum = d_s + ((a_s - b_s) <<< 1) + INC_SE;

        offset_a_next = offset_a_reg;
        offset_b_next = offset_b_reg;
        decision_next = decision_reg;
        held_cx_next  = held_cx_reg;
        held_cy_next  = held_cy_reg;
        job_load      = 1'b0;

        if (accept && action == mcr_pkg::ACT_START)
        begin
            held_cx_next  = center_x;
            held_cy_next  = center_y;
            offset_a_next = '0;
            offset_b_next = circle_radius;
            decision_next = mcr_pkg::dec_t'(ONE - r_s);
            job_load      = 1'b1;
        end
        else if (accept && busy_reg)
        begin
            // Step: diagonal move drops y, east move keeps it
            if (decision_reg >= 0)
                offset_b_next = offset_b_reg - 1'b1;
            decision_next = mcr_pkg::dec_t'(sum);
            offset_a_next = offset_a_reg + 1'b1;
            job_load      = 1'b1;
        end

        busy_next = job_load ? (offset_a_next < offset_b_next) : busy_reg;

        job.cx   = held_cx_next;
        job.cy   = held_cy_next;
        job.a    = offset_a_next;
        job.b    = offset_b_next;
        job.done = !busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_a_reg <= '0;
            offset_b_reg <= '0;
            decision_reg <= '0;
            held_cx_reg  <= '0;
            held_cy_reg  <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            offset_a_reg <= offset_a_next;
            offset_b_reg <= offset_b_next;
            decision_reg <= decision_next;
            held_cx_reg  <= held_cx_next;
            held_cy_reg  <= held_cy_next;
            busy_reg     <= busy_next;
        end
    end

    a_busy_order: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> offset_a_reg < offset_b_reg)
        else $error("busy set while x has reached y");

endmodule

// ===== sv/mcr_emit.sv =====
// Eight-point octant sequencer with a registered pixel output.
`timescale 1ns / 1ps

module mcr_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_load,
    input  mcr_pkg::job_t job,
    output logic          take,
    mcr_pix_if.source     pix
);

    mcr_pkg::job_t job_reg;
    logic          job_valid_reg, job_valid_next;
    mcr_pkg::oct_t k_reg, k_next;

    logic          out_valid_reg, out_valid_next;
    mcr_pkg::pix_t px_reg, py_reg, px_next, py_next;
    mcr_pkg::oct_t oct_reg;
    logic          last_reg, done_reg;

    logic          out_free, advance, finish;
    mcr_pkg::pix_t cx_s, cy_s, a_s, b_s, dx, dy;

    always_comb
    begin
        out_free = !out_valid_reg || pix.ready;
        advance  = job_valid_reg && out_free;
        finish   = advance && k_reg == mcr_pkg::OCT_LAST;
        take     = !job_valid_reg || finish;

        cx_s = $signed({{(mcr_pkg::PIX_BITS-mcr_pkg::COORD_BITS){1'b0}}, job_reg.cx});
        cy_s = $signed({{(mcr_pkg::PIX_BITS-mcr_pkg::COORD_BITS){1'b0}}, job_reg.cy});
        a_s  = $signed({{(mcr_pkg::PIX_BITS-mcr_pkg::RAD_BITS){1'b0}}, job_reg.a});
        b_s  = $signed({{(mcr_pkg::PIX_BITS-mcr_pkg::RAD_BITS){1'b0}}, job_reg.b});

        // Bit 2 swaps the offsets, bit 0 mirrors x, bit 1 mirrors y
        dx = k_reg[2] ? b_s : a_s;
        dy = k_reg[2] ? a_s : b_s;
        px_next = k_reg[0] ? cx_s - dx : cx_s + dx;
        py_next = k_reg[1] ? cy_s - dy : cy_s + dy;

        if (job_load)
            job_valid_next = 1'b1;
        else if (finish)
            job_valid_next = 1'b0;
        else
            job_valid_next = job_valid_reg;

        if (job_load)
            k_next = '0;
        else if (advance)
            k_next = k_reg + 1'b1;
        else
            k_next = k_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (pix.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
        if (advance)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            oct_reg  <= k_reg;
            last_reg <= k_reg == mcr_pkg::OCT_LAST;
            done_reg <= k_reg == mcr_pkg::OCT_LAST && job_reg.done;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_x      = px_reg;
    assign pix.pixel_y      = py_reg;
    assign pix.octant       = oct_reg;
    assign pix.last_of_step = last_reg;
    assign pix.circle_done  = done_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> !job_valid_reg || finish)
        else $error("job loaded over an unfinished iteration");

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |=> job_valid_reg && k_reg == '0)
        else $error("loaded job does not start at the first octant");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg && oct_reg == mcr_pkg::OCT_LAST)
        else $error("circle done flagged away from the last octant");

endmodule

// ===== sv/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer top level: command channel in, pixel channel out.
// A command's job is registered, then its first point in the pixel output register.
// Throughput: one point per cycle while the pixel channel is ready; a start or busy step is
// held until the single pixel output register has taken all eight octants of its iteration.
// A step while idle is accepted and yields no points.
// Reset (rst_n low, asynchronous) clears the circle state to idle and empties the output.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer (
    input  logic      clk,
    input  logic      rst_n,
    mcr_cmd_if.sink   cmd,
    mcr_pix_if.source pixel
);

    logic          accept;
    logic          take;
    logic          job_load;
    mcr_pkg::job_t job;

    assign cmd.ready = take;
    assign accept    = cmd.valid && take;

    mcr_iter u_iter (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .action        (cmd.action),
        .center_x      (cmd.center_x),
        .center_y      (cmd.center_y),
        .circle_radius (cmd.circle_radius),
        .job_load      (job_load),
        .job           (job)
    );

    mcr_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_load (job_load),
        .job      (job),
        .take     (take),
        .pix      (pixel)
    );

endmodule
